[design/pei_pkg.sv]
package pei_pkg;

    localparam int LOG_TABLE_BITS_DEF = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ACCEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd2;

    localparam logic [23:0] GRAVITY_ACCEL_RST = 24'd642253;
    localparam logic [23:0] TIME_STEP_RST = 24'd1092;

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // log2(1 + i/2^bits) in Q0.16, elaboration only
    function automatic logic [63:0] log_entry(input logic [63:0] i, input int bits);
        logic [63:0] x;
        logic [63:0] r;
        x = (64'd1 << 30) + (i << (30 - bits));
        r = '0;
        for (int b = 0; b < 16; b++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r = r | 64'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v = v_in;
        res = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(-j/2^bits) in Q1.30, elaboration only
    function automatic logic [63:0] exp_entry(input logic [63:0] j, input int bits);
        logic [63:0] e;
        logic [63:0] root;
        e = 64'd1 << 30;
        root = 64'd1 << 29;
        for (int n = 1; n <= bits; n++) begin
            root = isqrt64(root << 30);
            if (j[bits-n]) e = (e * root) >> 30;
        end
        return e;
    endfunction

endpackage

[design/pei_damp.sv]
module pei_damp #(
    parameter int LOG_TABLE_BITS = pei_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [16:0] damping,
    input  logic [23:0] time_step,
    output logic [16:0] factor
);
    import pei_pkg::*;

    localparam int TBL = 1 << LOG_TABLE_BITS;

    logic [15:0] logt [TBL];
    logic [30:0] expt [TBL];

    for (genvar g = 0; g < TBL; g++) begin : g_tbl
        assign logt[g] = 16'(log_entry(64'(g), LOG_TABLE_BITS));
        assign expt[g] = 31'(exp_entry(64'(g), LOG_TABLE_BITS));
    end

    // stage 1: mantissa index and exponent
    logic [3:0]                k_next, k_reg;
    logic [15:0]               m_norm;
    logic [LOG_TABLE_BITS-1:0] idx_reg;
    logic                      zero1_reg, one1_reg;

    always_comb begin
        k_next = '0;
        for (int b = 0; b < 16; b++) begin
            if (damping[b]) k_next = 4'(b);
        end
        m_norm = damping[15:0] << (4'd15 - k_next);
    end

    // stage 2: -log2(d) in Q.16
    logic [20:0] l_reg;
    logic        zero2_reg, one2_reg;
    // stage 3: time_step * L
    logic [44:0] prod_reg;
    logic        zero3_reg, one3_reg;

    // stage 4: exp2 and scale
    logic [28:0]               e_full;
    logic [12:0]               ei;
    logic [LOG_TABLE_BITS-1:0] jdx;
    logic [6:0]                shamt;
    logic [63:0]               rnd;
    logic [16:0]               factor_next, factor_reg;

    always_comb begin
        e_full = 29'((prod_reg + 45'd32768) >> 16);
        ei = e_full[28:16];
        jdx = e_full[15 -: LOG_TABLE_BITS];
        shamt = 7'(ei[5:0]) + 7'd14;
        rnd = ({33'd0, expt[jdx]} + (64'd1 << (shamt - 7'd1))) >> shamt;
        if (zero3_reg) begin
            factor_next = '0;
        end else if (one3_reg) begin
            factor_next = 17'd65536;
        end else if (ei > 13'd40) begin
            factor_next = '0;
        end else begin
            factor_next = rnd[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg <= k_next;
            idx_reg <= m_norm[14 -: LOG_TABLE_BITS];
            zero1_reg <= (damping == 17'd0);
            one1_reg <= damping[16];
            l_reg <= {5'd16 - {1'b0, k_reg}, 16'd0} - {5'd0, logt[idx_reg]};
            zero2_reg <= zero1_reg;
            one2_reg <= one1_reg;
            prod_reg <= {21'd0, time_step} * {24'd0, l_reg};
            zero3_reg <= zero2_reg;
            one3_reg <= one2_reg;
            factor_reg <= factor_next;
        end
    end

    assign factor = factor_reg;

endmodule

[design/particle_euler_integrator_top.sv]
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | pos, vel, acc, inv_mass, damping, flags
// m_      | out       | m_valid / m_ready   | new pos, new vel, skipped, last_out
// cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// One particle per cycle sustained while m_ready does not stall the output; accept to m_valid runs through all stages.
// Six register stages, the damping exp2/log2 path sets the depth.
// Synchronous active-low reset clears valid bits and loads config registers with their reset values.
// A stall at m_ready freezes the whole pipe; s_ready drops only while the
// output holds a request that is not taken.
module particle_euler_integrator_top #(
    parameter int LOG_TABLE_BITS = pei_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pei_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pei_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_pos_x,
    input  logic signed [31:0]              s_pos_y,
    input  logic signed [31:0]              s_vel_x,
    input  logic signed [31:0]              s_vel_y,
    input  logic signed [31:0]              s_acc_x,
    input  logic signed [31:0]              s_acc_y,
    input  logic [31:0]                     s_inv_mass,
    input  logic [16:0]                     s_damping,
    input  logic                            s_freeze,
    input  logic                            s_ignore_gravity,
    input  logic                            s_last_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_new_pos_x,
    output logic signed [31:0]              m_new_pos_y,
    output logic signed [31:0]              m_new_vel_x,
    output logic signed [31:0]              m_new_vel_y,
    output logic                            m_skipped,
    output logic                            m_last_out
);
    import pei_pkg::*;

    logic        grav_en_reg;
    logic [23:0] grav_reg;
    logic [23:0] ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_en_reg <= 1'b0;
            grav_reg <= GRAVITY_ACCEL_RST;
            ts_reg <= TIME_STEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRAVITY_ENABLE: grav_en_reg <= cfg_wdata[0];
                REG_GRAVITY_ACCEL:  grav_reg <= cfg_wdata[23:0];
                REG_TIME_STEP:      ts_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [5:0] vld_reg;

    assign en = !vld_reg[5] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], s_valid};
        end
    end

    logic [16:0] factor;

    pei_damp #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_damp (
        .aclk     (aclk),
        .en       (en),
        .damping  (s_damping),
        .time_step(ts_reg),
        .factor   (factor)
    );

    logic signed [24:0] dt_s;
    assign dt_s = $signed({1'b0, ts_reg});

    // stage 1
    logic signed [31:0] p1x_reg, p1y_reg, v1x_reg, v1y_reg;
    logic signed [32:0] a1x_reg, a1y_reg, a1y_next;
    always_comb begin
        a1y_next = 33'(s_acc_y);
        if (grav_en_reg && !s_ignore_gravity) begin
            a1y_next = 33'(s_acc_y) - $signed({9'd0, grav_reg});
        end
    end

    // stage 2
    logic signed [31:0] p2x_reg, p2y_reg, v2x_reg, v2y_reg;
    logic signed [56:0] mvx_reg, mvy_reg;
    logic signed [57:0] max_reg, may_reg;

    // stage 3
    logic signed [40:0] rvx, rvy;
    logic signed [41:0] rax, ray;
    logic [31:0] p3x_reg, p3y_reg;
    logic signed [31:0] v3x_reg, v3y_reg;
    logic signed [42:0] t3x_reg, t3y_reg;

    // stage 4
    logic [31:0] p4x_reg, p4y_reg;
    logic signed [31:0] v4x_reg, v4y_reg;
    logic signed [42:0] t4x_reg, t4y_reg;

    // stage 5
    logic [31:0] p5x_reg, p5y_reg;
    logic signed [31:0] v5x_reg, v5y_reg;
    logic signed [60:0] d5x_reg, d5y_reg;
    logic signed [44:0] rdx, rdy;

    // stage 6 (output)
    logic [31:0] ox_reg, oy_reg, ovx_reg, ovy_reg;
    logic [5:0] sk_reg, la_reg;

    always_comb begin
        rvx = 41'((mvx_reg + 57'sd32768) >>> 16);
        rvy = 41'((mvy_reg + 57'sd32768) >>> 16);
        rax = 42'((max_reg + 58'sd32768) >>> 16);
        ray = 42'((may_reg + 58'sd32768) >>> 16);
        rdx = 45'((d5x_reg + 61'sd32768) >>> 16);
        rdy = 45'((d5y_reg + 61'sd32768) >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1x_reg <= s_pos_x;
            p1y_reg <= s_pos_y;
            v1x_reg <= s_vel_x;
            v1y_reg <= s_vel_y;
            a1x_reg <= 33'(s_acc_x);
            a1y_reg <= a1y_next;
            sk_reg[0] <= s_freeze || (s_inv_mass == 32'd0);
            la_reg[0] <= s_last_in;

            p2x_reg <= p1x_reg;
            p2y_reg <= p1y_reg;
            v2x_reg <= v1x_reg;
            v2y_reg <= v1y_reg;
            mvx_reg <= 57'(v1x_reg) * 57'(dt_s);
            mvy_reg <= 57'(v1y_reg) * 57'(dt_s);
            max_reg <= 58'(a1x_reg) * 58'(dt_s);
            may_reg <= 58'(a1y_reg) * 58'(dt_s);

            p3x_reg <= sk_reg[1] ? p2x_reg : sat32(64'(p2x_reg) + 64'(rvx));
            p3y_reg <= sk_reg[1] ? p2y_reg : sat32(64'(p2y_reg) + 64'(rvy));
            v3x_reg <= v2x_reg;
            v3y_reg <= v2y_reg;
            t3x_reg <= 43'(v2x_reg) + 43'(rax);
            t3y_reg <= 43'(v2y_reg) + 43'(ray);

            p4x_reg <= p3x_reg;
            p4y_reg <= p3y_reg;
            v4x_reg <= v3x_reg;
            v4y_reg <= v3y_reg;
            t4x_reg <= t3x_reg;
            t4y_reg <= t3y_reg;

            p5x_reg <= p4x_reg;
            p5y_reg <= p4y_reg;
            v5x_reg <= v4x_reg;
            v5y_reg <= v4y_reg;
            d5x_reg <= 61'(t4x_reg) * 61'($signed({1'b0, factor}));
            d5y_reg <= 61'(t4y_reg) * 61'($signed({1'b0, factor}));

            ox_reg <= p5x_reg;
            oy_reg <= p5y_reg;
            ovx_reg <= sk_reg[4] ? v5x_reg : sat32(64'(rdx));
            ovy_reg <= sk_reg[4] ? v5y_reg : sat32(64'(rdy));

            sk_reg[5:1] <= sk_reg[4:0];
            la_reg[5:1] <= la_reg[4:0];
        end
    end

    assign m_valid = vld_reg[5];
    assign m_new_pos_x = ox_reg;
    assign m_new_pos_y = oy_reg;
    assign m_new_vel_x = ovx_reg;
    assign m_new_vel_y = ovy_reg;
    assign m_skipped = sk_reg[5];
    assign m_last_out = la_reg[5];

endmodule
